// File: rtl/core/murmur_hash_64a_macros.svh
// Assertion macros shared by the murmur_hash_64a core.
// Expects signals named clk and arst_n in the module that uses them.
`ifndef MURMUR_HASH_64A_MACROS_SVH
`define MURMUR_HASH_64A_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define MH64_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mh64 assertion failed");

// Antecedent implies consequent in the next cycle.
`define MH64_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mh64 assertion failed");

`endif

// File: rtl/core/mh64_pkg.sv
// Shared types and constants of the murmur_hash_64a core.
// No dependencies; used by every module of the core.
`timescale 1ns / 1ps

package mh64_pkg;

	localparam logic [63:0] MixMul   = 64'hc6a4a7935bd1e995;
	localparam int          MixShift = 47;

	localparam int WordW   = 64;
	localparam int CountW  = 4;
	localparam int LenW    = 32;
	localparam int InDataW = 104;
	localparam int FullBytes = 8;

	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	// What a word does to the running hash.
	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_PART  = 2'd1,
		KIND_FULL  = 2'd2
	} kind_t;

	// One classified item, as passed from the front to the back.
	typedef struct packed {
		logic               first;
		logic               last;
		kind_t              kind;
		logic [WordW-1:0]   word;   // already masked to its valid bytes
		logic [LenW-1:0]    len;
	} cmd_t;

	// Request to the shared constant multiplier.
	typedef struct packed {
		logic             start;
		logic [WordW-1:0] operand;
	} mul_req_t;

	// Result of the shared constant multiplier.
	typedef struct packed {
		logic             done;
		logic             busy;
		logic [WordW-1:0] product;
	} mul_rsp_t;

endpackage

// File: rtl/core/mh64_queue.sv
// Two-entry command queue between the front and the back of the hasher.
// Depends on mh64_pkg and murmur_hash_64a_macros.svh.
`timescale 1ns / 1ps
`include "murmur_hash_64a_macros.svh"

module mh64_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mh64_pkg::cmd_t  push_cmd,
	input  logic            pop,
	output mh64_pkg::cmd_t  head,
	output logic            empty,
	output logic            full
);

	mh64_pkg::cmd_t                     mem_q [mh64_pkg::QueueDepth];
	logic [mh64_pkg::QueuePtrW-1:0]     wr_ptr_q;
	logic [mh64_pkg::QueuePtrW-1:0]     rd_ptr_q;
	logic [mh64_pkg::QueueCntW-1:0]     count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == mh64_pkg::QueueCntW'(mh64_pkg::QueueDepth));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == mh64_pkg::QueuePtrW'(mh64_pkg::QueueDepth - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == mh64_pkg::QueuePtrW'(mh64_pkg::QueueDepth - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`MH64_ASSERT_NEXT(a_pop_drains, pop && !push, count_q == $past(count_q) - 1'b1)
	`MH64_ASSERT_NEXT(a_push_fills, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

// File: rtl/core/mh64_mul.sv
// Iterative multiplier by the mix constant, modulo 2^64, one 32x32 product a cycle.
// Depends on mh64_pkg and murmur_hash_64a_macros.svh.
`timescale 1ns / 1ps
`include "murmur_hash_64a_macros.svh"

module mh64_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  mh64_pkg::mul_req_t req,
	output mh64_pkg::mul_rsp_t rsp
);

	typedef enum logic [1:0] {
		STEP_LO       = 2'd0,
		STEP_CROSS_LO = 2'd1,
		STEP_CROSS_HI = 2'd2
	} step_t;

	logic [63:0] a_q;
	logic [63:0] acc_q;
	step_t       step_q;
	logic        busy_q;
	logic [31:0] op_x;
	logic [31:0] op_y;
	logic [63:0] prod;
	logic [31:0] hi_sum;
	logic        done;

	// Low*low gives the full low half; the two cross terms add only into bits 63:32.
	always_comb begin
		unique case (step_q)
			STEP_LO: begin
				op_x = a_q[31:0];
				op_y = mh64_pkg::MixMul[31:0];
			end
			STEP_CROSS_LO: begin
				op_x = a_q[31:0];
				op_y = mh64_pkg::MixMul[63:32];
			end
			STEP_CROSS_HI: begin
				op_x = a_q[63:32];
				op_y = mh64_pkg::MixMul[31:0];
			end
			default: begin
				op_x = '0;
				op_y = '0;
			end
		endcase
	end

	assign prod   = {32'd0, op_x} * {32'd0, op_y};
	assign hi_sum = acc_q[63:32] + prod[31:0];
	assign done   = busy_q && (step_q == STEP_CROSS_HI);

	assign rsp.done    = done;
	assign rsp.busy    = busy_q;
	assign rsp.product = {hi_sum, acc_q[31:0]};

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.operand;
		end
		if (busy_q) begin
			unique case (step_q)
				STEP_LO:       acc_q <= prod;
				STEP_CROSS_LO: acc_q <= {hi_sum, acc_q[31:0]};
				default:       acc_q <= acc_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_LO;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= STEP_LO;
		end else if (busy_q) begin
			unique case (step_q)
				STEP_LO:       step_q <= STEP_CROSS_LO;
				STEP_CROSS_LO: step_q <= STEP_CROSS_HI;
				default: begin
					step_q <= STEP_LO;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	`MH64_ASSERT_IMP(a_no_overlap, req.start, !busy_q || done)

endmodule

// File: rtl/core/mh64_front.sv
// Input side of the hasher: accepts stream transactions and classifies each word.
// Depends on mh64_pkg.
`timescale 1ns / 1ps

module mh64_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mh64_pkg::InDataW-1:0]   s_tdata,
	input  logic                           s_tlast,
	input  logic                           queue_full,
	output logic                           push,
	output mh64_pkg::cmd_t                 push_cmd
);

	logic [mh64_pkg::WordW-1:0]  word;
	logic [mh64_pkg::CountW-1:0] nbytes;
	logic [mh64_pkg::WordW-1:0]  mask;
	logic                        first_q;

	assign word   = s_tdata[mh64_pkg::WordW-1:0];
	assign nbytes = s_tdata[mh64_pkg::WordW +: mh64_pkg::CountW];

	assign s_tready = !queue_full;
	assign push     = s_tvalid && s_tready;

	// Keep byte i when it lies below the valid count; counts above eight keep all.
	always_comb begin
		for (int i = 0; i < mh64_pkg::FullBytes; i++) begin
			mask[8*i +: 8] = (nbytes > mh64_pkg::CountW'(i)) ? 8'hff : 8'h00;
		end
	end

	always_comb begin
		push_cmd.first = first_q;
		push_cmd.last  = s_tlast;
		push_cmd.word  = word & mask;
		push_cmd.len   = s_tdata[mh64_pkg::WordW + mh64_pkg::CountW +: mh64_pkg::LenW];
		priority if (nbytes >= mh64_pkg::CountW'(mh64_pkg::FullBytes)) begin
			push_cmd.kind = mh64_pkg::KIND_FULL;
		end else if (nbytes != '0) begin
			push_cmd.kind = mh64_pkg::KIND_PART;
		end else begin
			push_cmd.kind = mh64_pkg::KIND_EMPTY;
		end
	end

	// Track message boundaries: the word after a last mark opens a new message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (push) begin
			first_q <= s_tlast;
		end
	end

endmodule

// File: rtl/core/mh64_back.sv
// Execution side of the hasher: sequences the mix steps on the shared multiplier
// and holds the result register. Depends on mh64_pkg, mh64_mul and the macro header.
`timescale 1ns / 1ps
`include "murmur_hash_64a_macros.svh"

module mh64_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [mh64_pkg::WordW-1:0]  seed,
	input  mh64_pkg::cmd_t              head,
	input  logic                        queue_empty,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mh64_pkg::WordW-1:0]  m_tdata
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_INIT = 7'b0000010,
		ST_MIX1 = 7'b0000100,
		ST_MIX2 = 7'b0001000,
		ST_FOLD = 7'b0010000,
		ST_FIN  = 7'b0100000,
		ST_PUSH = 7'b1000000
	} state_t;

	typedef struct packed {
		logic                       start;
		logic [mh64_pkg::WordW-1:0] operand;
		state_t                     state;
		logic [mh64_pkg::WordW-1:0] h;
	} step_t;

	state_t                      state_q;
	mh64_pkg::cmd_t              cmd_q;
	logic [mh64_pkg::WordW-1:0]  h_q;
	logic                        out_valid_q;
	logic [mh64_pkg::WordW-1:0]  out_data_q;

	mh64_pkg::mul_req_t          mul_req;
	mh64_pkg::mul_rsp_t          mul_rsp;
	step_t                       nxt;
	logic                        load_out;
	logic [mh64_pkg::WordW-1:0]  p;

	mh64_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	assign p = mul_rsp.product;

	function automatic logic [63:0] xsh(input logic [63:0] v);
		xsh = v ^ (v >> mh64_pkg::MixShift);
	endfunction

	// End of a word: finalize on the last mark, else wait for the next word.
	function automatic step_t finish(input logic last, input logic [63:0] hv);
		step_t s;
		s.h = hv;
		if (last) begin
			s.start   = 1'b1;
			s.operand = xsh(hv);
			s.state   = ST_FIN;
		end else begin
			s.start   = 1'b0;
			s.operand = '0;
			s.state   = ST_IDLE;
		end
		finish = s;
	endfunction

	function automatic step_t dispatch(input mh64_pkg::cmd_t c, input logic [63:0] hv);
		step_t s;
		logic [63:0] t;
		t = hv ^ c.word;
		unique case (c.kind)
			mh64_pkg::KIND_FULL: begin
				s = '{start: 1'b1, operand: c.word, state: ST_MIX1, h: hv};
			end
			mh64_pkg::KIND_PART: begin
				s = '{start: 1'b1, operand: t, state: ST_FOLD, h: t};
			end
			default: begin
				s = finish(c.last, hv);
			end
		endcase
		dispatch = s;
	endfunction

	always_comb begin
		nxt      = '{start: 1'b0, operand: '0, state: state_q, h: h_q};
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!queue_empty) begin
					pop = 1'b1;
					if (head.first) begin
						nxt = '{start: 1'b1, operand: {32'd0, head.len}, state: ST_INIT,
							h: h_q};
					end else begin
						nxt = dispatch(head, h_q);
					end
				end
			end
			ST_INIT: begin
				if (mul_rsp.done) begin
					nxt = dispatch(cmd_q, seed ^ p);
				end
			end
			ST_MIX1: begin
				if (mul_rsp.done) begin
					nxt = '{start: 1'b1, operand: xsh(p), state: ST_MIX2, h: h_q};
				end
			end
			ST_MIX2: begin
				if (mul_rsp.done) begin
					nxt = '{start: 1'b1, operand: h_q ^ p, state: ST_FOLD, h: h_q ^ p};
				end
			end
			ST_FOLD: begin
				if (mul_rsp.done) begin
					nxt = finish(cmd_q.last, p);
				end
			end
			ST_FIN: begin
				if (mul_rsp.done) begin
					nxt = '{start: 1'b0, operand: '0, state: ST_PUSH, h: xsh(p)};
				end
			end
			ST_PUSH: begin
				if (!out_valid_q || m_tready) begin
					load_out  = 1'b1;
					nxt.state = ST_IDLE;
				end
			end
			default: begin
				nxt.state = ST_IDLE;
			end
		endcase
	end

	assign mul_req.start   = nxt.start;
	assign mul_req.operand = nxt.operand;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk) begin
		h_q <= nxt.h;
		if (pop) begin
			cmd_q <= head;
		end
		if (load_out) begin
			out_data_q <= h_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt.state;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`MH64_ASSERT_NEXT(a_fin_to_push, (state_q == ST_FIN) && mul_rsp.done, state_q == ST_PUSH)
	`MH64_ASSERT_NEXT(a_load_shows, load_out, out_valid_q)

endmodule

// File: rtl/core/murmur_hash_64a.sv
// Top level of the streaming MurmurHash64A core.
// Depends on mh64_pkg, mh64_front, mh64_queue and mh64_back.
// Usage:
//   Stream each message as 64-bit little-endian words on the s_ channel. Every
//   transaction carries the word, its valid byte count and the total message
//   length (read on the first word of a message only); s_tlast marks the final
//   word. A zero-length message is one transaction with zero valid bytes and
//   s_tlast set. Each message yields one hash on the m_ channel. The user must
//   write the seed via cfg_we / cfg_wdata only while the core is idle; unchecked.
// Multiplier use:
//   The back end runs every multiply by the mix constant on one shared 32x32
//   multiplier. A full word costs three 64-bit products, a partial word one and an
//   empty word none. The first word of a message adds the length product;
//   the last adds the finalization product and a load of the output register.
//   A two-entry queue lets the input accept up to two words ahead of the back end.
// Reset and stalls:
//   arst_n clears the seed, the queue, the sequencer and the output valid flag.
//   While m_tready is low a finished hash holds in the output register; the back
//   end keeps hashing the next message until it has a new result to present.
`timescale 1ns / 1ps

module murmur_hash_64a (
	input  logic                          clk,
	input  logic                          arst_n,
	// Seed register write.
	input  logic                          cfg_we,
	input  logic [mh64_pkg::WordW-1:0]    cfg_wdata,
	// Input stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata: [63:0] data_word, [67:64] valid_bytes, [99:68] total_length, rest zero
	input  logic [mh64_pkg::InDataW-1:0]  s_tdata,
	input  logic                          s_tlast,   // last_word
	// Result stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata: [63:0] hash_value
	output logic [mh64_pkg::WordW-1:0]    m_tdata
);

	logic [mh64_pkg::WordW-1:0] seed_q;
	logic                       push;
	logic                       pop;
	logic                       queue_full;
	logic                       queue_empty;
	mh64_pkg::cmd_t             push_cmd;
	mh64_pkg::cmd_t             head;

	// Hold the seed; the back end samples it at each message start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	mh64_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	mh64_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (queue_empty),
		.full     (queue_full)
	);

	mh64_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed        (seed_q),
		.head        (head),
		.queue_empty (queue_empty),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

// File: verif/testbench.sv
// Self-checking bench for the murmur_hash_64a streaming hasher.
// Needs mh64_pkg and the core RTL. A predictor class tracks the expected
// hashes; plain tasks drive the seed port and the input, an always block m_tready.
`timescale 1ns / 1ps

module testbench;
	import mh64_pkg::*;

	// Running MurmurHash64A state plus the hashes still owed by the core.
	class hash_tracker;
		logic [WordW-1:0] seed;
		logic [WordW-1:0] acc;
		bit               open;
		logic [WordW-1:0] hash_due_q[$];
		int               errors;

		function new();
			seed   = '0;
			acc    = '0;
			open   = 1'b0;
			errors = 0;
		endfunction

		function void set_seed(logic [WordW-1:0] v);
			seed = v;
		endfunction

		// Fold one accepted input transaction into the running hash.
		function void take_word(logic [WordW-1:0] word, logic [CountW-1:0] nbytes,
				bit last, logic [LenW-1:0] len);
			logic [WordW-1:0] k;
			logic [WordW-1:0] h;
			logic [WordW-1:0] mask;
			int               n;
			n = (nbytes > FullBytes) ? FullBytes : int'(nbytes);
			if (!open) begin
				acc  = seed ^ (WordW'(len) * MixMul);
				open = 1'b1;
			end
			h = acc;
			if (n == FullBytes) begin
				k = word * MixMul;
				k = k ^ (k >> MixShift);
				k = k * MixMul;
				h = h ^ k;
				h = h * MixMul;
			end else if (n != 0) begin
				mask = (64'd1 << (8 * n)) - 64'd1;
				h = h ^ (word & mask);
				h = h * MixMul;
			end
			acc = h;
			if (last) begin
				h = h ^ (h >> MixShift);
				h = h * MixMul;
				h = h ^ (h >> MixShift);
				hash_due_q.push_back(h);
				acc  = '0;
				open = 1'b0;
			end
		endfunction

		// Compare one accepted result transaction with the oldest owed hash.
		function void match_hash(logic [WordW-1:0] got);
			logic [WordW-1:0] want;
			if (hash_due_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected hash, expected none, got %h", $time, got);
			end else begin
				want = hash_due_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: hash mismatch, expected %h, got %h", $time, want, got);
				end
			end
		endfunction
	endclass

	localparam int SettleCycles = 80;   // covers two queued words plus the one in flight
	localparam int PhaseItems   = 320;
	localparam int Phases       = 6;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [WordW-1:0]    cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [WordW-1:0]    m_tdata;

	hash_tracker tracker = new();
	bit          no_idle = 1'b0;   // suppress gaps and stalls on both sides
	int          rx_hold = 0;
	int          sent_count = 0;

	murmur_hash_64a u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [63:0] data_word, [67:64] valid_bytes, [99:68] total_length
		.s_tlast   (s_tlast),   // last_word
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)    // [63:0] hash_value
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: check every accepted transaction, then draw a random stall on m_tready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				tracker.match_hash(m_tdata);
				rx_hold = no_idle ? 0 : $urandom_range(0, 3);
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [WordW-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Drive one input transaction; called at a rising edge, returns at the accepting edge.
	// Keep s_tvalid high across back-to-back transactions.
	task automatic send_item(input logic [WordW-1:0] word, input logic [CountW-1:0] nbytes,
			input bit last, input logic [LenW-1:0] len);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, len, nbytes, word};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.take_word(word, nbytes, last, len);
		sent_count++;
	endtask

	// Drop valid, hold until every owed hash is back, then let the core drain.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.hash_due_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_seed(input logic [WordW-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tracker.set_seed(v);
	endtask

	// Well-formed message: nwords full words, then a tail of 0 to 7 bytes.
	task automatic send_message(input int nwords, input int tail, input logic [LenW-1:0] len);
		for (int i = 0; i < nwords; i++)
			send_item(rand_word(), CountW'(FullBytes), (i == nwords - 1) && (tail == 0), len);
		if (tail != 0 || nwords == 0)
			send_item(rand_word(), CountW'(tail), 1'b1, len);
	endtask

	initial begin
		int r;
		int nw;
		int tail;
		int burst;
		logic [WordW-1:0] phase_seed;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		m_tready  <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, seed still at its reset value.
		send_item('0, 4'd0, 1'b1, 32'd0);                 // empty message
		send_item('1, 4'd8, 1'b1, 32'd8);                 // all-ones word
		send_item('0, 4'd8, 1'b1, 32'd8);                 // all-zeros word
		for (int n = 1; n < FullBytes; n++)
			send_item('1, CountW'(n), 1'b1, LenW'(n));    // tails, junk above the valid bytes
		send_item(rand_word(), 4'd15, 1'b0, 32'd16);      // counts above eight saturate
		send_item(rand_word(), 4'd9, 1'b1, 32'd16);
		send_item(rand_word(), 4'd0, 1'b0, 32'd8);        // empty first word opens the message
		send_item(rand_word(), 4'd8, 1'b1, 32'd8);
		send_item(rand_word(), 4'd3, 1'b0, 32'd11);       // partial word not marked last
		send_item(rand_word(), 4'd8, 1'b1, 32'd11);
		send_item(rand_word(), 4'd8, 1'b0, 32'hffff_ffff); // length disagrees with the data
		send_item(rand_word(), 4'd8, 1'b1, 32'hffff_ffff);
		// Seed change inside an open message applies from the next message only.
		send_item(rand_word(), 4'd8, 1'b0, 32'd16);
		settle();
		write_seed('1);
		send_item(rand_word(), 4'd8, 1'b1, 32'd16);
		send_message(2, 5, 32'd21);
		send_item('0, 4'd0, 1'b1, 32'd0);

		// Random part: one seed per phase, extremes first.
		for (int ph = 0; ph < Phases; ph++) begin
			settle();
			case (ph)
				0: phase_seed = '0;
				1: phase_seed = '1;
				2: phase_seed = 64'h8000_0000_0000_0001;
				default: phase_seed = rand_word();
			endcase
			write_seed(phase_seed);
			no_idle = (ph == 3);
			while (sent_count < 25 + (ph + 1) * PhaseItems) begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					nw = $urandom_range(8, 16);
				end else begin
					nw = $urandom_range(0, 7);
				end
				tail = $urandom_range(0, 7);
				if (r < 80) begin
					send_message(nw, tail, LenW'(8 * nw + tail));
				end else if (r < 90) begin
					send_message(nw, tail, $urandom);
				end else begin
					// Noise: arbitrary counts and last marks.
					burst = $urandom_range(1, 6);
					for (int j = 0; j < burst; j++)
						send_item(rand_word(), CountW'($urandom_range(0, 15)),
							$urandom_range(0, 3) == 0, $urandom);
				end
			end
		end

		settle();
		if (tracker.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Hard limit: several times the slowest legal run.
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/mh64_pkg.sv
rtl/core/mh64_queue.sv
rtl/core/mh64_mul.sv
rtl/core/mh64_front.sv
rtl/core/mh64_back.sv
rtl/core/murmur_hash_64a.sv
verif/testbench.sv
